// ===== rtl/keypad_code_lock_with_servo_macros.svh =====
// Assertion macros for the keypad code lock checker.
// Used by kcl_checker.sv only; it needs no other file.
`ifndef KEYPAD_CODE_LOCK_WITH_SERVO_MACROS_SVH
`define KEYPAD_CODE_LOCK_WITH_SERVO_MACROS_SVH

// Property sampled at the rising clock edge and ignored while reset is active.
`define KCL_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Property that must also hold while reset is active.
`define KCL_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== rtl/kcl_pkg.sv =====
// Shared types and constants for the keypad code lock with servo drive.
// Used by the top level and by the port checker; depends on nothing.
package kcl_pkg;

	// Code and field widths.
	localparam int CODE_DIGITS = 4;
	localparam int DIGIT_W     = 4;
	localparam int CODE_W      = CODE_DIGITS * DIGIT_W;
	localparam int KEY_W       = 5;
	localparam int IDX_W       = $clog2(CODE_DIGITS);
	localparam int PWM_W       = 5;
	localparam int TICK_W      = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_W        = 8;
	localparam int OUT_W       = 48;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_PERIOD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_PERIOD  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_TICKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_WIDTH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_WIDTH = 3'd5;

	// Configuration reset values.
	localparam logic [TICK_W-1:0] KEY_PERIOD_RST   = 16'd10;
	localparam logic [TICK_W-1:0] PAGE_PERIOD_RST  = 16'd1000;
	localparam logic [TICK_W-1:0] UNLOCK_TICKS_RST = 16'd1000;
	localparam logic [PWM_W-1:0]  PWM_TOP_RST      = 5'd20;
	localparam logic [PWM_W-1:0]  OPEN_WIDTH_RST   = 5'd2;
	localparam logic [PWM_W-1:0]  CLOSED_WIDTH_RST = 5'd1;

	// Keypad codes.
	localparam logic [KEY_W-1:0] KEY_ONE    = 5'd1;
	localparam logic [KEY_W-1:0] KEY_ZERO   = 5'd10;
	localparam logic [KEY_W-1:0] KEY_MODE   = 5'd13;
	localparam logic [KEY_W-1:0] KEY_TARGET = 5'd14;

	// Digit values; the first digit sits in the low nibble.
	localparam logic [DIGIT_W-1:0] DIGIT_ZERO     = 4'd0;
	localparam logic [DIGIT_W-1:0] DIGIT_EMPTY    = 4'hF;
	localparam logic [CODE_W-1:0]  EMPTY_ENTRY    = {CODE_DIGITS{DIGIT_EMPTY}};
	localparam logic [CODE_W-1:0]  USER_CODE_RST  = 16'h4321;
	localparam logic [CODE_W-1:0]  MASTER_CODE_RST = 16'h1234;

	// One result item as it travels on the output tdata, last field lowest.
	typedef struct packed {
		logic [5:0]        pad;
		logic [CODE_W-1:0] save_code;
		logic              save_target;
		logic              save_valid;
		logic [IDX_W-1:0]  entry_count;
		logic [CODE_W-1:0] entry_digits;
		logic              change_master;
		logic              master_mode;
		logic              admin_page;
		logic              door_open;
		logic              lock_drive;
		logic              servo_pulse;
	} result_t;

endpackage

// ===== rtl/keypad_code_lock_with_servo.sv =====
// Top level of the keypad code lock with servo drive.
// Uses kcl_pkg for widths, codes, reset values and the result layout.
//
// Channel   Direction  Payload (low bit first)
// s_axis    in         tdata[4:0] key_code, tdata[7:5] zero
// m_axis    out        tdata: servo_pulse, lock_drive, door_open, admin_page,
//                      master_mode, change_master, entry_digits[15:0],
//                      entry_count[1:0], save_valid, save_target,
//                      save_code[15:0], six zero bits
// cfg       in         cfg_we, cfg_index[2:0], cfg_data[15:0]
//
// Each tick item is processed combinationally: the lock state and the result
// register update together at the edge that accepts it, so one item per cycle while the output is not stalled.
// The result register decouples the sides: a new item is taken whenever the
// result register is empty or its item is taken in the same cycle.
// Reset (arst_n low) restores the power-up codes, flags, dividers and settings.
module keypad_code_lock_with_servo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [kcl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kcl_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [kcl_pkg::IN_W-1:0]        s_axis_tdata,  // key_code[4:0], zero fill
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [kcl_pkg::OUT_W-1:0]       m_axis_tdata   // fields as in kcl_pkg::result_t
);

	// Configuration registers.
	logic [kcl_pkg::TICK_W-1:0] key_period_q, page_period_q, unlock_ticks_q;
	logic [kcl_pkg::PWM_W-1:0]  pwm_top_q, open_width_q, closed_width_q;

	// Lock state.
	logic [kcl_pkg::KEY_W-1:0]  prev_key_q, prev_key_n;
	logic [kcl_pkg::TICK_W-1:0] key_div_q, key_div_n, page_div_q, page_div_n;
	logic [kcl_pkg::CODE_W-1:0] entry_q, entry_n;
	logic [kcl_pkg::IDX_W-1:0]  idx_q, idx_n;
	logic [kcl_pkg::CODE_W-1:0] user_code_q, user_code_n, master_code_q, master_code_n;
	logic door_q, door_n, master_q, master_n, menter_q, menter_n;
	logic change_q, change_n, admin_q, admin_n, return_q, return_n;
	logic [kcl_pkg::TICK_W-1:0] timer_q, timer_n;
	logic [kcl_pkg::PWM_W-1:0]  pwm_q, pwm_n, width_q, width_n;
	logic servo_q, servo_n, lock_q, lock_n;

	// Per-item working signals.
	logic [kcl_pkg::KEY_W-1:0]  key, down;
	logic [kcl_pkg::PWM_W:0]    count;
	logic                       key_fire, page_fire, full;
	logic                       save_valid, save_target;
	logic [kcl_pkg::CODE_W-1:0] save_code;
	kcl_pkg::result_t           result;

	// Result register.
	logic                       out_valid_q;
	kcl_pkg::result_t           out_q;
	logic                       in_acc;

	assign key           = s_axis_tdata[kcl_pkg::KEY_W-1:0];
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// Next state for one tick: servo step, then key step, then page step.
	always_comb begin
		prev_key_n    = prev_key_q;
		entry_n       = entry_q;
		idx_n         = idx_q;
		user_code_n   = user_code_q;
		master_code_n = master_code_q;
		door_n        = door_q;
		master_n      = master_q;
		menter_n      = menter_q;
		change_n      = change_q;
		admin_n       = admin_q;
		return_n      = return_q;
		timer_n       = timer_q;
		width_n       = width_q;
		lock_n        = lock_q;
		save_valid    = 1'b0;
		save_target   = 1'b0;
		save_code     = '0;
		full          = 1'b0;

		// Servo step: the open timer runs while the door is open.
		count = {1'b0, pwm_q} + 6'd1;
		if (door_q) begin
			timer_n = timer_q + 16'd1;
			width_n = open_width_q;
			if (timer_n == unlock_ticks_q) begin
				width_n = closed_width_q;
				door_n  = 1'b0;
				timer_n = '0;
			end
		end
		servo_n = servo_q;
		if (count <= {1'b0, width_n}) begin
			servo_n = 1'b1;
		end else if (count <= {1'b0, pwm_top_q}) begin
			servo_n = 1'b0;
		end
		pwm_n = (count > {1'b0, pwm_top_q}) ? '0 : count[kcl_pkg::PWM_W-1:0];

		// Step dividers; a period of zero fires on every tick.
		key_fire   = (key_div_q <= 16'd1);
		key_div_n  = key_fire ? key_period_q : key_div_q - 16'd1;
		page_fire  = (page_div_q <= 16'd1);
		page_div_n = page_fire ? page_period_q : page_div_q - 16'd1;

		// Key step: act on bits that rose since the last sample.
		down = key & (key ^ prev_key_q);
		if (key_fire) begin
			prev_key_n = key;
			if (down == kcl_pkg::KEY_MODE) begin
				master_n = !master_q;
			end
			if (down == kcl_pkg::KEY_TARGET) begin
				change_n = !change_q;
			end
			if (down >= kcl_pkg::KEY_ONE && down <= kcl_pkg::KEY_ZERO) begin
				entry_n[{idx_q, 2'b00} +: kcl_pkg::DIGIT_W] = (down == kcl_pkg::KEY_ZERO) ?
					kcl_pkg::DIGIT_ZERO : down[kcl_pkg::DIGIT_W-1:0];
				if (idx_q == kcl_pkg::IDX_W'(kcl_pkg::CODE_DIGITS - 1)) begin
					full = 1'b1;
				end else begin
					idx_n = idx_q + 1'b1;
				end
			end
			// A complete entry is checked on the main page or stored on the admin page.
			if (full) begin
				if (!admin_q) begin
					if (!master_n) begin
						door_n = (entry_n == user_code_q);
					end else begin
						menter_n = (entry_n == master_code_q);
					end
				end else begin
					if (change_n) begin
						master_code_n = entry_n;
					end else begin
						user_code_n = entry_n;
					end
					save_valid  = 1'b1;
					save_target = change_n;
					save_code   = entry_n;
					return_n    = 1'b1;
				end
				entry_n = kcl_pkg::EMPTY_ENTRY;
				idx_n   = '0;
			end
		end

		// Page step: lock output and page changes; the entry index is kept.
		if (page_fire) begin
			if (!admin_n) begin
				lock_n = !door_n;
				if (master_n && menter_n) begin
					entry_n  = kcl_pkg::EMPTY_ENTRY;
					door_n   = 1'b0;
					master_n = 1'b0;
					menter_n = 1'b0;
					change_n = 1'b0;
					admin_n  = 1'b1;
					return_n = 1'b0;
				end
			end else if (return_n) begin
				entry_n  = kcl_pkg::EMPTY_ENTRY;
				door_n   = 1'b0;
				master_n = 1'b0;
				menter_n = 1'b0;
				change_n = 1'b0;
				admin_n  = 1'b0;
				return_n = 1'b0;
			end
		end

		// Assemble the result item.
		result               = '0;
		result.servo_pulse   = servo_n;
		result.lock_drive    = lock_n;
		result.door_open     = door_n;
		result.admin_page    = admin_n;
		result.master_mode   = master_n;
		result.change_master = change_n;
		result.entry_digits  = entry_n;
		result.entry_count   = idx_n;
		result.save_valid    = save_valid;
		result.save_target   = save_target;
		result.save_code     = save_code;
	end

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_period_q   <= kcl_pkg::KEY_PERIOD_RST;
			page_period_q  <= kcl_pkg::PAGE_PERIOD_RST;
			unlock_ticks_q <= kcl_pkg::UNLOCK_TICKS_RST;
			pwm_top_q      <= kcl_pkg::PWM_TOP_RST;
			open_width_q   <= kcl_pkg::OPEN_WIDTH_RST;
			closed_width_q <= kcl_pkg::CLOSED_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				kcl_pkg::CFG_KEY_PERIOD:   key_period_q   <= cfg_data;
				kcl_pkg::CFG_PAGE_PERIOD:  page_period_q  <= cfg_data;
				kcl_pkg::CFG_UNLOCK_TICKS: unlock_ticks_q <= cfg_data;
				kcl_pkg::CFG_PWM_TOP:      pwm_top_q      <= cfg_data[kcl_pkg::PWM_W-1:0];
				kcl_pkg::CFG_OPEN_WIDTH:   open_width_q   <= cfg_data[kcl_pkg::PWM_W-1:0];
				kcl_pkg::CFG_CLOSED_WIDTH: closed_width_q <= cfg_data[kcl_pkg::PWM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Lock state advances once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_key_q    <= '0;
			key_div_q     <= kcl_pkg::KEY_PERIOD_RST;
			page_div_q    <= kcl_pkg::PAGE_PERIOD_RST;
			entry_q       <= kcl_pkg::EMPTY_ENTRY;
			idx_q         <= '0;
			user_code_q   <= kcl_pkg::USER_CODE_RST;
			master_code_q <= kcl_pkg::MASTER_CODE_RST;
			door_q        <= 1'b0;
			master_q      <= 1'b0;
			menter_q      <= 1'b0;
			change_q      <= 1'b0;
			admin_q       <= 1'b0;
			return_q      <= 1'b0;
			timer_q       <= '0;
			pwm_q         <= '0;
			width_q       <= kcl_pkg::CLOSED_WIDTH_RST;
			servo_q       <= 1'b0;
			lock_q        <= 1'b1;
		end else if (in_acc) begin
			prev_key_q    <= prev_key_n;
			key_div_q     <= key_div_n;
			page_div_q    <= page_div_n;
			entry_q       <= entry_n;
			idx_q         <= idx_n;
			user_code_q   <= user_code_n;
			master_code_q <= master_code_n;
			door_q        <= door_n;
			master_q      <= master_n;
			menter_q      <= menter_n;
			change_q      <= change_n;
			admin_q       <= admin_n;
			return_q      <= return_n;
			timer_q       <= timer_n;
			pwm_q         <= pwm_n;
			width_q       <= width_n;
			servo_q       <= servo_n;
			lock_q        <= lock_n;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, loaded with each accepted item.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_q <= result;
		end
	end

endmodule

// ===== rtl/kcl_checker.sv =====
// Port-level checker for the keypad code lock, bound to the top level.
// Depends on kcl_pkg and keypad_code_lock_with_servo_macros.svh.
`include "keypad_code_lock_with_servo_macros.svh"

module kcl_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tready,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [kcl_pkg::OUT_W-1:0]   m_axis_tdata
);

	kcl_pkg::result_t r;

	assign r = kcl_pkg::result_t'(m_axis_tdata);

	// A stalled result item keeps its valid and its payload.
	`KCL_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result item changed")

	// With no result pending the block always takes a new item.
	`KCL_ASSERT_ALWAYS(a_ready_when_empty, clk, !m_axis_tvalid |-> s_axis_tready, "input stalled while output empty")

	// Save fields are zero unless a code was saved.
	`KCL_ASSERT(a_save_quiet, clk, arst_n, m_axis_tvalid && !r.save_valid |-> r.save_target == 1'b0 && r.save_code == '0, "save fields set without save")

	// A save ends the attempt: the entry is emptied and restarts at the first digit.
	`KCL_ASSERT(a_save_clears, clk, arst_n, m_axis_tvalid && r.save_valid |-> r.entry_count == '0 && r.entry_digits == kcl_pkg::EMPTY_ENTRY, "entry not cleared on save")

	// The door is never open on the code change page.
	`KCL_ASSERT(a_admin_closed, clk, arst_n, m_axis_tvalid && r.admin_page |-> !r.door_open, "door open on admin page")

endmodule

bind keypad_code_lock_with_servo kcl_checker u_kcl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
